FILE: sv/lppr_pkg.sv
// ----------------------------------------------------------------------------
// Length-prefixed packet reassembler package
// Shared codes, widths, defaults and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package lppr_pkg;

    localparam int CAPACITY_DEF     = 4096;
    localparam int HEADER_BYTES_DEF = 4;

    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;
    localparam int CLEN_W = 13;
    localparam int LEN_W  = 16;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOPKT  = 2'd2;

    localparam logic [LEN_W-1:0] LEN_MASK   = 16'h7FFF;
    localparam int               MIN_STORED = 2;

    typedef struct packed {
        logic accept;
        logic rd1;
        logic rd2;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic req_pop;
        logic need_hdr;
        logic out_free;
    } t_sts;

endpackage

FILE: sv/length_prefixed_packet_reassembler.sv
// Push, clear and unknown words pass from S_IDLE to S_OUT; a pop inside a packet also passes
// S_RD1 and one that reads the length S_RD1 and S_RD2, as both length bytes are read through
// the single port of the ring RAM with registered read data. A new word is taken only in
// S_IDLE, once the last result has been loaded into the output register, which waits on its
// receiver while it still holds an unread result.
// Synchronous active-low reset empties the ring and clears framed mode; the RAM keeps its data.
// ----------------------------------------------------------------------------
// Length-prefixed packet reassembler
// Ring buffer taking byte chunks and returning whole length-prefixed packets.
// ----------------------------------------------------------------------------
module length_prefixed_packet_reassembler
    import lppr_pkg::*;
#(
    parameter int CAPACITY     = CAPACITY_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // data_byte[7:0], chunk_first[8], chunk_length[21:9], zero pad[23:22]
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // req_type[1:0]
    input  logic [REQ_W-1:0]    i_s_tuser,
    input  logic                i_s_tlast,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // out_byte[7:0], packet_first[8], packet_length[24:9], zero pad[31:25]
    output logic [M_DATA_W-1:0] o_m_tdata,
    // status[1:0]
    output logic [STAT_W-1:0]   o_m_tuser,
    output logic                o_m_tlast
);

    localparam int AW = $clog2(CAPACITY);

    t_cmd          cmd;
    t_sts          sts;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;
    logic          chunk_last_unused;

    // The end-of-chunk mark carries no meaning for the ring.
    assign chunk_last_unused = i_s_tlast;

    lppr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lppr_dp #(
        .CAPACITY     (CAPACITY),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    lppr_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

endmodule

FILE: sv/lppr_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module lppr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/lppr_ctrl.sv
// ----------------------------------------------------------------------------
// Reassembler controller
// Sequences acceptance, the one or two ring reads of a pop and the result hand-off.
// ----------------------------------------------------------------------------
module lppr_ctrl
    import lppr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD1  = 4'b0010,
        S_RD2  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_sts.req_pop ? S_RD1 : S_OUT;
                end
            end
            S_RD1: begin
                o_cmd.rd1 = 1'b1;
                n_state   = i_sts.need_hdr ? S_RD2 : S_OUT;
            end
            S_RD2: begin
                o_cmd.rd2 = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: sv/lppr_dp.sv
// ----------------------------------------------------------------------------
// Reassembler datapath
// Ring indices, fill count, packet length check, result and output registers.
// ----------------------------------------------------------------------------
module lppr_dp
    import lppr_pkg::*;
#(
    parameter int CAPACITY     = CAPACITY_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    output t_sts                        o_sts,
    input  logic [S_DATA_W-1:0]         i_s_tdata,
    input  logic [REQ_W-1:0]            i_s_tuser,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_wdata,
    output logic                        o_ram_we,
    output logic [$clog2(CAPACITY)-1:0] o_ram_addr,
    output logic [7:0]                  o_ram_wdata,
    input  logic [7:0]                  i_ram_rdata,
    input  logic                        i_m_tready,
    output logic                        o_m_tvalid,
    output logic [M_DATA_W-1:0]         o_m_tdata,
    output logic [STAT_W-1:0]           o_m_tuser,
    output logic                        o_m_tlast
);

    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = ((FW > CLEN_W) ? FW : CLEN_W) + 1;
    localparam int LW = ((FW > LEN_W) ? FW : LEN_W) + 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
    localparam logic [FW-1:0] FULL      = FW'(CAPACITY);

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
        return (idx == LAST_SLOT) ? '0 : idx + 1'b1;
    endfunction

    logic [REQ_W-1:0]  in_req;
    logic [7:0]        in_data;
    logic              in_first;
    logic [CLEN_W-1:0] in_clen;

    logic [AW-1:0]    r_rd, n_rd, r_wr, n_wr;
    logic [FW-1:0]    r_fill, n_fill;
    logic [LEN_W-1:0] r_left, n_left;
    logic             r_reject, n_reject;
    logic             r_framed, n_framed;
    logic             r_out_valid, n_out_valid;

    logic [7:0]        r_lo, n_lo;
    logic [STAT_W-1:0] r_res_status, n_res_status;
    logic [7:0]        r_res_byte, n_res_byte;
    logic              r_res_first, n_res_first;
    logic              r_res_last, n_res_last;
    logic [LEN_W-1:0]  r_res_len, n_res_len;

    logic [STAT_W-1:0] r_o_status;
    logic [7:0]        r_o_byte;
    logic              r_o_first;
    logic              r_o_last;
    logic [LEN_W-1:0]  r_o_len;

    logic [AW-1:0]    rd_next;
    logic [CW-1:0]    chunk_sum;
    logic             push_reject;
    logic             push_ok;
    logic             is_push;
    logic             has_cont;
    logic             short_store;
    logic [LEN_W-1:0] raw_len;
    logic [LEN_W-1:0] hdr_len;
    logic             len_ok;

    assign in_req   = i_s_tuser;
    assign in_data  = i_s_tdata[7:0];
    assign in_first = i_s_tdata[8];
    assign in_clen  = i_s_tdata[21:9];

    assign rd_next     = next_slot(r_rd);
    assign chunk_sum   = CW'(r_fill) + CW'(in_clen);
    assign push_reject = in_first ? (chunk_sum > CW'(CAPACITY)) : r_reject;
    assign push_ok     = !push_reject && (r_fill != FULL);
    assign is_push     = (in_req == REQ_PUSH);
    assign has_cont    = (r_left != '0) && (r_fill != '0);
    assign short_store = (r_fill <= FW'(MIN_STORED));
    assign raw_len     = {i_ram_rdata, r_lo};
    assign hdr_len     = r_framed ? ((raw_len & LEN_MASK) + LEN_W'(HEADER_BYTES)) : raw_len;
    assign len_ok      = (hdr_len != '0) && (LW'(hdr_len) <= LW'(r_fill));

    assign o_ram_we    = i_cmd.accept && is_push && push_ok;
    assign o_ram_addr  = i_cmd.rd1 ? rd_next : (is_push ? r_wr : r_rd);
    assign o_ram_wdata = in_data;

    assign o_sts.req_pop  = (in_req == REQ_POP);
    assign o_sts.need_hdr = !has_cont && !short_store;
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_rd         = r_rd;
        n_wr         = r_wr;
        n_fill       = r_fill;
        n_left       = r_left;
        n_reject     = r_reject;
        n_framed     = r_framed;
        n_out_valid  = r_out_valid;
        n_lo         = r_lo;
        n_res_status = r_res_status;
        n_res_byte   = r_res_byte;
        n_res_first  = r_res_first;
        n_res_last   = r_res_last;
        n_res_len    = r_res_len;

        if (i_cmd.accept) begin
            n_res_status = ST_OK;
            n_res_byte   = '0;
            n_res_first  = 1'b0;
            n_res_last   = 1'b0;
            n_res_len    = '0;
            case (in_req)
                REQ_PUSH: begin
                    n_reject = push_reject;
                    if (push_ok) begin
                        n_wr   = next_slot(r_wr);
                        n_fill = r_fill + 1'b1;
                    end else begin
                        n_res_status = ST_REJECT;
                    end
                end
                REQ_CLEAR: begin
                    n_rd     = '0;
                    n_wr     = '0;
                    n_fill   = '0;
                    n_left   = '0;
                    n_reject = 1'b0;
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.rd1) begin
            if (has_cont) begin
                n_rd       = rd_next;
                n_fill     = r_fill - 1'b1;
                n_left     = r_left - 1'b1;
                n_res_byte = i_ram_rdata;
                n_res_last = (r_left == LEN_W'(1));
            end else if (short_store) begin
                n_left       = '0;
                n_res_status = ST_NOPKT;
            end else begin
                n_lo = i_ram_rdata;
            end
        end

        if (i_cmd.rd2) begin
            if (len_ok) begin
                n_rd        = rd_next;
                n_fill      = r_fill - 1'b1;
                n_left      = hdr_len - 1'b1;
                n_res_byte  = r_lo;
                n_res_first = 1'b1;
                n_res_len   = hdr_len;
                n_res_last  = (hdr_len == LEN_W'(1));
            end else begin
                n_res_status = ST_NOPKT;
            end
        end

        if (i_cfg_we) begin
            n_framed = i_cfg_wdata;
        end

        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd        <= '0;
            r_wr        <= '0;
            r_fill      <= '0;
            r_left      <= '0;
            r_reject    <= 1'b0;
            r_framed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd        <= n_rd;
            r_wr        <= n_wr;
            r_fill      <= n_fill;
            r_left      <= n_left;
            r_reject    <= n_reject;
            r_framed    <= n_framed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo         <= n_lo;
        r_res_status <= n_res_status;
        r_res_byte   <= n_res_byte;
        r_res_first  <= n_res_first;
        r_res_last   <= n_res_last;
        r_res_len    <= n_res_len;
        if (i_cmd.load_out) begin
            r_o_status <= r_res_status;
            r_o_byte   <= r_res_byte;
            r_o_first  <= r_res_first;
            r_o_last   <= r_res_last;
            r_o_len    <= r_res_len;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_o_len, r_o_first, r_o_byte};
    assign o_m_tuser  = r_o_status;
    assign o_m_tlast  = r_o_last;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL)
        else $error("Fill count exceeds the ring capacity.");

    a_left_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_left) <= LW'(r_fill))
        else $error("Packet bytes still to go exceed the stored bytes.");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |=> (r_fill != '0) && (r_fill == $past(r_fill) + 1'b1))
        else $error("A ring write did not advance the fill count.");
`endif

endmodule
